/* src/shb_pkg.sv */
// ----------------------------------------------------------------------------
// shb_pkg: shared types, constants and round functions
// Word type, command codes, controller states, initial hash values, the
// round constant table and the SHA-256 sigma functions.
// ----------------------------------------------------------------------------
package shb_pkg;

   typedef logic [31:0] word_type;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int IDX_W   = 3;
   localparam int FILL_W  = 7;
   localparam int COUNT_W = 61;
   localparam int RND_W   = 6;
   localparam int BLK_W   = 512;
   localparam int LEN_W   = 64;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ABSORB   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FINALIZE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART  = 2'd2;

   localparam logic [FILL_W-1:0] BLOCK_BYTES = 7'd64;
   localparam logic [FILL_W-1:0] LEN_POS     = 7'd56;
   localparam logic [BYTE_W-1:0] PAD_MARK    = 8'h80;
   localparam logic [RND_W-1:0]  LAST_ROUND  = 6'd63;
   localparam logic [IDX_W-1:0]  LAST_WORD   = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FEED,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam word_type IV [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // round constant table
   function automatic word_type round_k(input logic [RND_W-1:0] idx);
      unique case (idx)
         6'd0:  round_k = 32'h428A2F98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hB5C0FBCF;  6'd3:  round_k = 32'hE9B5DBA5;
         6'd4:  round_k = 32'h3956C25B;  6'd5:  round_k = 32'h59F111F1;
         6'd6:  round_k = 32'h923F82A4;  6'd7:  round_k = 32'hAB1C5ED5;
         6'd8:  round_k = 32'hD807AA98;  6'd9:  round_k = 32'h12835B01;
         6'd10: round_k = 32'h243185BE;  6'd11: round_k = 32'h550C7DC3;
         6'd12: round_k = 32'h72BE5D74;  6'd13: round_k = 32'h80DEB1FE;
         6'd14: round_k = 32'h9BDC06A7;  6'd15: round_k = 32'hC19BF174;
         6'd16: round_k = 32'hE49B69C1;  6'd17: round_k = 32'hEFBE4786;
         6'd18: round_k = 32'h0FC19DC6;  6'd19: round_k = 32'h240CA1CC;
         6'd20: round_k = 32'h2DE92C6F;  6'd21: round_k = 32'h4A7484AA;
         6'd22: round_k = 32'h5CB0A9DC;  6'd23: round_k = 32'h76F988DA;
         6'd24: round_k = 32'h983E5152;  6'd25: round_k = 32'hA831C66D;
         6'd26: round_k = 32'hB00327C8;  6'd27: round_k = 32'hBF597FC7;
         6'd28: round_k = 32'hC6E00BF3;  6'd29: round_k = 32'hD5A79147;
         6'd30: round_k = 32'h06CA6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27B70A85;  6'd33: round_k = 32'h2E1B2138;
         6'd34: round_k = 32'h4D2C6DFC;  6'd35: round_k = 32'h53380D13;
         6'd36: round_k = 32'h650A7354;  6'd37: round_k = 32'h766A0ABB;
         6'd38: round_k = 32'h81C2C92E;  6'd39: round_k = 32'h92722C85;
         6'd40: round_k = 32'hA2BFE8A1;  6'd41: round_k = 32'hA81A664B;
         6'd42: round_k = 32'hC24B8B70;  6'd43: round_k = 32'hC76C51A3;
         6'd44: round_k = 32'hD192E819;  6'd45: round_k = 32'hD6990624;
         6'd46: round_k = 32'hF40E3585;  6'd47: round_k = 32'h106AA070;
         6'd48: round_k = 32'h19A4C116;  6'd49: round_k = 32'h1E376C08;
         6'd50: round_k = 32'h2748774C;  6'd51: round_k = 32'h34B0BCB5;
         6'd52: round_k = 32'h391C0CB3;  6'd53: round_k = 32'h4ED8AA4A;
         6'd54: round_k = 32'h5B9CCA4F;  6'd55: round_k = 32'h682E6FF3;
         6'd56: round_k = 32'h748F82EE;  6'd57: round_k = 32'h78A5636F;
         6'd58: round_k = 32'h84C87814;  6'd59: round_k = 32'h8CC70208;
         6'd60: round_k = 32'h90BEFFFA;  6'd61: round_k = 32'hA4506CEB;
         6'd62: round_k = 32'hBEF9A3F7;  6'd63: round_k = 32'hC67178F2;
      endcase
   endfunction

endpackage

/* src/shb_if.sv */
// ----------------------------------------------------------------------------
// shb_req_if / shb_rsp_if: valid/ready channels of the hasher
// Request channel carries a command and a data byte; response channel
// carries one digest word with its index and a last flag.
// ----------------------------------------------------------------------------
interface shb_req_if import shb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface shb_rsp_if import shb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] digest_word;
   logic [IDX_W-1:0]  word_index;
   logic              last;

   modport source (output valid, output digest_word, output word_index, output last,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last,
                   output ready);
endinterface

/* src/shb_round.sv */
// ----------------------------------------------------------------------------
// shb_round: one SHA-256 round and one message schedule step
// Combinational round function over the working variables, plus the next
// schedule word from the 16-word window taps.
// ----------------------------------------------------------------------------
module shb_round import shb_pkg::*; (
   input  word_type v_cur [8],
   input  word_type w0,
   input  word_type w1,
   input  word_type w9,
   input  word_type w14,
   input  word_type k,
   output word_type v_nxt [8],
   output word_type w_new
);

   word_type t1;
   word_type t2;
   word_type ch;
   word_type maj;

   // round update
   always_comb begin
      ch  = (v_cur[4] & v_cur[5]) ^ (~v_cur[4] & v_cur[6]);
      maj = (v_cur[0] & v_cur[1]) ^ (v_cur[0] & v_cur[2]) ^ (v_cur[1] & v_cur[2]);
      t1  = v_cur[7] + big_sigma1(v_cur[4]) + ch + k + w0;
      t2  = big_sigma0(v_cur[0]) + maj;
      v_nxt[0] = t1 + t2;
      v_nxt[1] = v_cur[0];
      v_nxt[2] = v_cur[1];
      v_nxt[3] = v_cur[2];
      v_nxt[4] = v_cur[3] + t1;
      v_nxt[5] = v_cur[4];
      v_nxt[6] = v_cur[5];
      v_nxt[7] = v_cur[6];
   end

   // schedule word entering the window
   assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

endmodule

/* src/sha256_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher: SHA-256 over a byte stream
// Absorbs one byte per word, compresses full blocks, pads and emits the
// digest on finalize.
// ----------------------------------------------------------------------------
// The 64th byte of a block starts 64 rounds and a feed-forward step, all
// run through the single round unit while req.ready is low. Finalize shifts
// the padding in one byte a cycle (64 - fill bytes, or 128 - fill when the
// length does not fit), runs one or two compressions, then presents the
// eight digest words, one per accepted rsp word. The block buffer is a
// 512-bit shift register that doubles as the message schedule window.
module sha256_byte_stream_hasher import shb_pkg::*; (
   input logic        clock,
   input logic        reset,
   shb_req_if.sink    req,
   shb_rsp_if.source  rsp
);

   state_type state_ff, state_in;
   word_type  chain_ff [8];
   word_type  chain_in [8];
   word_type  v_ff [8];
   word_type  v_in [8];
   word_type  v_rnd [8];
   word_type  w_new;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [RND_W-1:0]   rnd_ff, rnd_in;
   logic [IDX_W-1:0]   widx_ff, widx_in;
   logic               pad_ff, pad_in;
   logic               mark_ff, mark_in;
   logic               last_ff, last_in;
   logic [BYTE_W-1:0]  pad_byte;
   logic               req_fire;

   // shared round unit, window taps at fixed word positions
   shb_round u_round (
      .v_cur (v_ff),
      .w0    (blk_ff[511:480]),
      .w1    (blk_ff[479:448]),
      .w9    (blk_ff[223:192]),
      .w14   (blk_ff[63:32]),
      .k     (round_k(rnd_ff)),
      .v_nxt (v_rnd),
      .w_new (w_new)
   );

   assign req.ready       = (state_ff == ST_IDLE);
   assign req_fire        = req.valid && req.ready;
   assign rsp.valid       = (state_ff == ST_EMIT);
   assign rsp.digest_word = chain_ff[0];
   assign rsp.word_index  = widx_ff;
   assign rsp.last        = (widx_ff == LAST_WORD);

   // padding byte: marker, then zeros, then length on the final block
   always_comb begin
      priority if (!mark_ff) begin
         pad_byte = PAD_MARK;
      end else if (last_ff && (fill_ff >= LEN_POS)) begin
         pad_byte = len_ff[LEN_W-1 -: BYTE_W];
      end else begin
         pad_byte = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      v_in     = v_ff;
      blk_in   = blk_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      len_in   = len_ff;
      rnd_in   = rnd_ff;
      widx_in  = widx_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req.command)
                  CMD_ABSORB: begin
                     blk_in   = {blk_ff[BLK_W-BYTE_W-1:0], req.data_byte};
                     fill_in  = fill_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                     if (fill_in == BLOCK_BYTES) begin
                        v_in     = chain_ff;
                        rnd_in   = '0;
                        state_in = ST_ROUND;
                     end
                  end
                  CMD_FINALIZE: begin
                     len_in   = {count_ff, 3'b000};
                     pad_in   = 1'b1;
                     mark_in  = 1'b0;
                     last_in  = (fill_ff < LEN_POS);
                     state_in = ST_PAD;
                  end
                  CMD_RESTART: begin
                     chain_in = IV;
                     fill_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAD: begin
            blk_in  = {blk_ff[BLK_W-BYTE_W-1:0], pad_byte};
            fill_in = fill_ff + 1'b1;
            mark_in = 1'b1;
            if (mark_ff && last_ff && (fill_ff >= LEN_POS)) begin
               len_in = {len_ff[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            end
            if (fill_in == BLOCK_BYTES) begin
               v_in     = chain_ff;
               rnd_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            v_in   = v_rnd;
            blk_in = {blk_ff[BLK_W-WORD_W-1:0], w_new};
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            fill_in = '0;
            if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (last_ff) begin
               widx_in  = '0;
               state_in = ST_EMIT;
            end else begin
               last_in  = 1'b1;
               state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               for (int i = 0; i < 7; i++) begin
                  chain_in[i] = chain_ff[i+1];
               end
               widx_in = widx_ff + 1'b1;
               if (widx_ff == LAST_WORD) begin
                  chain_in = IV;
                  fill_in  = '0;
                  count_in = '0;
                  pad_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff <= IV;
         fill_ff  <= '0;
         count_ff <= '0;
         rnd_ff   <= '0;
         widx_ff  <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         rnd_ff   <= rnd_in;
         widx_ff  <= widx_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         last_ff  <= last_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      blk_ff <= blk_in;
      len_ff <= len_in;
   end

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request accepted while digest is out");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (rnd_ff == LAST_ROUND) |=> (state_ff == ST_FEED))
      else $error("compression did not end after the last round");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last |=>
         (state_ff == ST_IDLE) && (fill_ff == '0) && (count_ff == '0))
      else $error("state not restarted after the digest");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < BLOCK_BYTES))
      else $error("block buffer overfilled");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sha256_byte_stream_hasher
// Feeds byte streams through the request channel and checks every digest
// word against a local SHA-256 hasher. A short table of fixed words runs
// first: the empty message, "abc", the unused command code, a restart in
// mid-message and the byte extremes. Random messages follow, with lengths
// around the padding and block boundaries, mixed with stray commands.
// Both channels idle at random, and the receiver holds off once for a long
// stretch so that the hasher stays on its digest and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
   import shb_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_WORDS   = 430;
   localparam int LONG_HOLD      = 500;
   localparam int DRAIN_CYCLES   = 300;
   localparam int DIRECTED_COUNT = 16;

   localparam logic [255:0] DIGEST_EMPTY =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] DIGEST_ABC =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

   localparam logic [31:0] H_INIT [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [IDX_W-1:0]  index;
      logic              last;
   } digest_word_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] data;
      logic              known;
      logic [255:0]      digest;
   } stim_row_type;

   // directed words; known digests are typed in, the rest are predicted
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{CMD_FINALIZE, 8'h00, 1'b1, DIGEST_EMPTY},
      '{CMD_ABSORB,   8'h61, 1'b0, 256'd0},
      '{CMD_ABSORB,   8'h62, 1'b0, 256'd0},
      '{CMD_ABSORB,   8'h63, 1'b0, 256'd0},
      '{CMD_FINALIZE, 8'h5A, 1'b1, DIGEST_ABC},
      '{CMD_ABSORB,   8'h00, 1'b0, 256'd0},
      '{CMD_UNUSED,   8'hFF, 1'b0, 256'd0},
      '{CMD_ABSORB,   8'hFF, 1'b0, 256'd0},
      '{CMD_RESTART,  8'hA5, 1'b0, 256'd0},
      '{CMD_FINALIZE, 8'h00, 1'b1, DIGEST_EMPTY},
      '{CMD_ABSORB,   8'h00, 1'b0, 256'd0},
      '{CMD_ABSORB,   8'hFF, 1'b0, 256'd0},
      '{CMD_FINALIZE, 8'hFF, 1'b0, 256'd0},
      '{CMD_UNUSED,   8'h00, 1'b0, 256'd0},
      '{CMD_RESTART,  8'h00, 1'b0, 256'd0},
      '{CMD_FINALIZE, 8'h00, 1'b1, DIGEST_EMPTY}
   };

   logic clock;
   logic reset;

   shb_req_if req_bus ();
   shb_rsp_if rsp_bus ();

   sha256_byte_stream_hasher dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   // local hasher state
   logic [31:0]       chain_val [8];
   logic [7:0]        block_buf [64];
   int unsigned       fill_cnt;
   logic [60:0]       byte_count;

   digest_word_type pending_digest_words [$];

   int  error_count;
   int  words_sent;
   int  absorb_count, finalize_count, restart_count, unused_count;
   int  words_checked;
   int  longest_message;
   bit  burst_mode;
   bit  long_hold_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5000000;
      $display("run limit reached with %0d digest words outstanding",
               pending_digest_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one 64-round compression of block_buf into chain_val
   function automatic void hash_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      int i;
      for (i = 0; i < 16; i++)
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      v = chain_val;
      for (i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++)
         chain_val[i] = chain_val[i] + v[i];
   endfunction

   function automatic void hasher_restart();
      chain_val  = H_INIT;
      fill_cnt   = 0;
      byte_count = '0;
   endfunction

   // apply one command; returns 1 with the digest when one is produced
   function automatic bit hasher_apply(input logic [CMD_W-1:0] cmd,
                                       input logic [BYTE_W-1:0] data,
                                       output logic [255:0] digest);
      logic [63:0] bit_len;
      int unsigned n;
      int i;
      digest = '0;
      case (cmd)
         CMD_ABSORB: begin
            block_buf[fill_cnt] = data;
            fill_cnt++;
            byte_count++;
            if (fill_cnt == BLOCK_BYTES) begin
               hash_block();
               fill_cnt = 0;
            end
            return 1'b0;
         end
         CMD_RESTART: begin
            hasher_restart();
            return 1'b0;
         end
         CMD_FINALIZE: begin
            if (byte_count > longest_message)
               longest_message = int'(byte_count);
            bit_len = {byte_count, 3'b000};
            n = fill_cnt;
            block_buf[n] = PAD_MARK;
            n++;
            // length field does not fit: pad out and compress an extra block
            if (n > LEN_POS) begin
               while (n < BLOCK_BYTES) begin
                  block_buf[n] = 8'h00;
                  n++;
               end
               hash_block();
               n = 0;
            end
            while (n < LEN_POS) begin
               block_buf[n] = 8'h00;
               n++;
            end
            for (i = 0; i < 8; i++)
               block_buf[LEN_POS + i] = bit_len[63 - 8*i -: 8];
            hash_block();
            digest = {chain_val[0], chain_val[1], chain_val[2], chain_val[3],
                      chain_val[4], chain_val[5], chain_val[6], chain_val[7]};
            hasher_restart();
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // message lengths clustered on the padding and block boundaries
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return $urandom_range(0, 12);
      else if (r < 8) begin
         case ($urandom_range(0, 8))
            0: return 54;
            1: return 55;
            2: return 56;
            3: return 57;
            4: return 63;
            5: return 64;
            6: return 65;
            7: return 119;
            default: return 120;
         endcase
      end else
         return $urandom_range(0, 130);
   endfunction

   // offer one word, wait for it to be taken, then predict its digest
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                            input bit known, input logic [255:0] known_digest);
      int gap;
      logic [255:0] digest;
      int k;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.data_byte <= data;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      case (cmd)
         CMD_ABSORB:   absorb_count++;
         CMD_FINALIZE: finalize_count++;
         CMD_RESTART:  restart_count++;
         default:      unused_count++;
      endcase
      if (cmd != CMD_UNUSED)
         words_sent++;
      if (hasher_apply(cmd, data, digest)) begin
         if (known)
            digest = known_digest;
         for (k = 0; k < 8; k++)
            pending_digest_words.push_back('{digest[255 - 32*k -: 32], IDX_W'(k),
                                             (k == LAST_WORD)});
      end
   endtask

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin : rsp_check
      digest_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_digest_words.size() == 0) begin
            $display("%0t: unexpected digest word, expected none, actual %h idx %0d last %0b",
                     $time, rsp_bus.digest_word, rsp_bus.word_index, rsp_bus.last);
            error_count++;
         end else begin
            want = pending_digest_words.pop_front();
            check_field("digest_word", want.word, rsp_bus.digest_word);
            check_field("word_index", 32'(want.index), 32'(rsp_bus.word_index));
            check_field("last", 32'(want.last), 32'(rsp_bus.last));
            words_checked++;
         end
      end
   end

   // receiver: random ready, one long hold-off once a random digest is due
   initial begin
      int run_len;
      int gap;
      rsp_bus.ready <= 1'b0;
      long_hold_done = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!long_hold_done && words_checked >= 32 && pending_digest_words.size() > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end
         run_len = $urandom_range(1, 60);
         rsp_bus.ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // sender and end of run
   initial begin
      int i;
      int msg_len;
      error_count     = 0;
      words_sent      = 0;
      absorb_count    = 0;
      finalize_count  = 0;
      restart_count   = 0;
      unused_count    = 0;
      words_checked   = 0;
      longest_message = 0;
      burst_mode      = 1'b0;
      for (i = 0; i < 64; i++)
         block_buf[i] = 8'h00;
      hasher_restart();

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.command   <= CMD_ABSORB;
      req_bus.data_byte <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < DIRECTED_COUNT; i++)
         send_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].data,
                   DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].digest);

      // random messages with stray commands in between
      while (words_sent < RANDOM_WORDS) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) == 0)
               send_word(CMD_RESTART, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            msg_len = pick_length();
            repeat (msg_len)
               send_word(CMD_ABSORB, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            send_word(CMD_FINALIZE, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 6))
               send_word(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                         1'b0, '0);
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_digest_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d absorb, %0d finalize, %0d restart and %0d unused-code words",
               absorb_count, finalize_count, restart_count, unused_count);
      $display("checked %0d digest words, longest message %0d bytes, long hold-off %0s",
               words_checked, longest_message, long_hold_done ? "done" : "not reached");
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
